@@ hw/rtl/iirl_pkg.sv @@
// Shared types and codes for the indexed insert/remove list.
package iirl_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 8;

	localparam logic [2:0] REQ_PUSH   = 3'd0;
	localparam logic [2:0] REQ_POP    = 3'd1;
	localparam logic [2:0] REQ_SET    = 3'd2;
	localparam logic [2:0] REQ_GET    = 3'd3;
	localparam logic [2:0] REQ_INSERT = 3'd4;
	localparam logic [2:0] REQ_REMOVE = 3'd5;

	typedef struct packed {
		logic [2:0]              req_type;
		logic [IDX_W-1:0]        position;
		logic signed [DATA_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
		logic [6:0]              entry_count;
		logic                    is_empty;
		logic                    full_refused;
	} rsp_t;

	// Broadcast to every cell in the transfer cycle.
	typedef struct packed {
		logic                    load;
		logic                    shift_up;
		logic                    shift_down;
		logic [IDX_W-1:0]        idx;
		logic signed [DATA_W-1:0] item_value;
	} cell_ctl_t;

	// Readout selects, valid after the update.
	typedef struct packed {
		logic [IDX_W-1:0] rd_idx;
		logic [IDX_W-1:0] bk_idx;
	} sel_t;

endpackage

@@ hw/rtl/iirl_cell.sv @@
// One list entry: holds a value, loads, or takes a neighbor's value on a shift.
module iirl_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  iirl_pkg::cell_ctl_t               ctl,
	input  iirl_pkg::sel_t                    sel,
	input  logic signed [iirl_pkg::DATA_W-1:0] lower,
	input  logic signed [iirl_pkg::DATA_W-1:0] upper,
	output logic signed [iirl_pkg::DATA_W-1:0] value,
	output logic [iirl_pkg::DATA_W-1:0]       rd_part,
	output logic [iirl_pkg::DATA_W-1:0]       bk_part
);
	import iirl_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic signed [DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		priority if (ctl.load && ctl.idx == MY_IDX) begin
			value_q <= ctl.item_value;
		end else if (ctl.shift_up && MY_IDX > ctl.idx) begin
			value_q <= lower;
		end else if (ctl.shift_down && MY_IDX >= ctl.idx) begin
			value_q <= upper;
		end
	end

	assign value   = value_q;
	assign rd_part = (sel.rd_idx == MY_IDX) ? value_q : '0;
	assign bk_part = (sel.bk_idx == MY_IDX) ? value_q : '0;

endmodule

@@ hw/rtl/iirl_reduce.sv @@
// Two-stage registered OR tree that collects the one selected cell value.
module iirl_reduce #(
	parameter int N = 64
) (
	input  logic                         clk,
	input  logic [iirl_pkg::DATA_W-1:0]  parts [N],
	output logic [iirl_pkg::DATA_W-1:0]  result
);
	import iirl_pkg::*;

	localparam int G = (N + 7) / 8;

	logic [DATA_W-1:0] grp_d  [G];
	logic [DATA_W-1:0] grp_s1 [G];
	logic [DATA_W-1:0] tot_d;
	logic [DATA_W-1:0] result_s2;

	always_comb begin
		for (int g = 0; g < G; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < 8; k++) begin
				if (g * 8 + k < N) begin
					grp_d[g] = grp_d[g] | parts[g * 8 + k];
				end
			end
		end
	end

	always_comb begin
		tot_d = '0;
		for (int g = 0; g < G; g++) begin
			tot_d = tot_d | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		grp_s1    <= grp_d;
		result_s2 <= tot_d;
	end

	assign result = result_s2;

endmodule

@@ hw/rtl/indexed_insert_remove_list.sv @@
// A request transfers in S_IDLE; its response is valid in S_OUT, after S_G1 and S_G2.
// req_stall holds until the response transfers, a wait set by the cell update plus the
// two-stage OR tree that reads the selected entry and the last entry out of the chain.
// Every cell shifts or loads in the transfer cycle, so insert and remove cost the same.
// Reset (arst_n low) clears the count and control; entries are not cleared, no sweep.
module indexed_insert_remove_list #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  iirl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output iirl_pkg::rsp_t rsp
);
	import iirl_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int XW    = CNT_W + IDX_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_G1   = 2'd1;
	localparam logic [1:0] S_G2   = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	sel_t             sel_q;
	sel_t             sel_d;
	logic             rd_en_q;
	logic             rd_en_d;
	logic             refused_q;
	logic             refused_d;
	cell_ctl_t        ctl;
	logic             accept;

	logic             full;
	logic             empty;
	logic [XW-1:0]    pos_x;
	logic [XW-1:0]    cnt_x;
	logic [XW-1:0]    clamp_x;
	logic [XW-1:0]    bk_x;

	logic signed [DATA_W-1:0] vals    [CAPACITY];
	logic [DATA_W-1:0]        rd_parts [CAPACITY];
	logic [DATA_W-1:0]        bk_parts [CAPACITY];
	logic [DATA_W-1:0]        rd_result;
	logic [DATA_W-1:0]        bk_result;
	logic [CNT_W+6:0]         cnt_ext;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_OUT);

	assign full    = (cnt_q == CNT_W'(CAPACITY));
	assign empty   = (cnt_q == '0);
	assign pos_x   = XW'(req.position);
	assign cnt_x   = XW'(cnt_q);
	assign clamp_x = (pos_x >= cnt_x) ? cnt_x - XW'(1) : pos_x;

	always_comb begin
		ctl            = '0;
		ctl.item_value = req.item_value;
		cnt_d          = cnt_q;
		rd_en_d        = 1'b0;
		refused_d      = 1'b0;
		unique case (req.req_type)
			REQ_PUSH, REQ_INSERT: begin
				if (full) begin
					refused_d = 1'b1;
				end else if (req.req_type == REQ_PUSH || pos_x >= cnt_x) begin
					ctl.load = 1'b1;
					ctl.idx  = cnt_x[IDX_W-1:0];
					cnt_d    = cnt_q + CNT_W'(1);
				end else begin
					ctl.load     = 1'b1;
					ctl.shift_up = 1'b1;
					ctl.idx      = req.position;
					cnt_d        = cnt_q + CNT_W'(1);
				end
			end
			REQ_POP: begin
				if (!empty) begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			REQ_SET: begin
				if (!empty) begin
					ctl.load = 1'b1;
					ctl.idx  = clamp_x[IDX_W-1:0];
				end
			end
			REQ_GET: begin
				rd_en_d = !empty;
			end
			REQ_REMOVE: begin
				if (!empty) begin
					if (pos_x < cnt_x) begin
						ctl.shift_down = 1'b1;
						ctl.idx        = req.position;
					end
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
		// cells move only on a transfer
		if (!accept) begin
			ctl.load       = 1'b0;
			ctl.shift_up   = 1'b0;
			ctl.shift_down = 1'b0;
		end
	end

	assign bk_x         = XW'(cnt_d) - XW'(1);
	assign sel_d.rd_idx = clamp_x[IDX_W-1:0];
	assign sel_d.bk_idx = bk_x[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_en_q   <= 1'b0;
			refused_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q   <= S_G1;
						cnt_q     <= cnt_d;
						rd_en_q   <= rd_en_d;
						refused_q <= refused_d;
					end
				end
				S_G1: state_q <= S_G2;
				S_G2: state_q <= S_OUT;
				S_OUT: begin
					if (!rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q <= sel_d;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] lower;
		logic signed [DATA_W-1:0] upper;
		if (i == 0) begin : g_first
			assign lower = req.item_value;
		end else begin : g_mid_lo
			assign lower = vals[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper = vals[i];
		end else begin : g_mid_hi
			assign upper = vals[i+1];
		end
		iirl_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.sel     (sel_q),
			.lower   (lower),
			.upper   (upper),
			.value   (vals[i]),
			.rd_part (rd_parts[i]),
			.bk_part (bk_parts[i])
		);
	end

	iirl_reduce #(.N(CAPACITY)) u_rd_tree (
		.clk    (clk),
		.parts  (rd_parts),
		.result (rd_result)
	);

	iirl_reduce #(.N(CAPACITY)) u_bk_tree (
		.clk    (clk),
		.parts  (bk_parts),
		.result (bk_result)
	);

	assign cnt_ext = (CNT_W + 7)'(cnt_q);

	always_comb begin
		rsp.read_value   = rd_en_q ? $signed(rd_result) : '0;
		rsp.front_value  = (cnt_q != '0) ? vals[0] : '0;
		rsp.back_value   = (cnt_q != '0) ? $signed(bk_result) : '0;
		rsp.entry_count  = cnt_ext[6:0];
		rsp.is_empty     = (cnt_q == '0);
		rsp.full_refused = refused_q;
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_G1 && refused_q) |-> cnt_q == CNT_W'(CAPACITY))
		else $error("refusal while list not full");

	a_no_req_during_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request taken while response pending");

	a_rsp_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_stall) |=> state_q == S_IDLE)
		else $error("no return to idle after response transfer");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CNT_W'(1)
			|| cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("count moved by more than one");
`endif

endmodule

@@ test/tb_indexed_insert_remove_list.sv @@
// Testbench for the indexed insert/remove list: directed, full-list, backpressure and random runs.
`timescale 1ns / 1ps

module tb_indexed_insert_remove_list;
	import iirl_pkg::*;

	localparam int          CAPACITY    = 64;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          HOLD_CYCLES = 200;
	localparam int          SETTLE      = 8;

	// request codes the block ignores
	localparam logic [2:0] REQ_UNUSED6 = 3'd6;
	localparam logic [2:0] REQ_UNUSED7 = 3'd7;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	// list contents as the block should hold them
	logic signed [DATA_W-1:0] lst_data [CAPACITY];
	int unsigned              lst_count = 0;
	rsp_t                     expected_rsps [$];

	int          mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int          tx_idle_pct    = 0;
	int          rx_stall_pct   = 0;
	logic        hold_on        = 1'b0;
	logic        grow_bias      = 1'b1;
	event        hold_go;

	indexed_insert_remove_list #(.CAPACITY(CAPACITY)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_stall <= hold_on || ($urandom_range(99) < rx_stall_pct);
	end

	// long receiver hold-off, counted here so the sender keeps pushing
	initial begin
		forever begin
			@(hold_go);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	// Applies one request to the list and returns the response it should produce.
	function automatic rsp_t list_apply(input req_t r);
		rsp_t        o;
		int unsigned idx;
		int unsigned i;
		o = '0;
		case (r.req_type)
			REQ_PUSH, REQ_INSERT: begin
				if (lst_count >= CAPACITY) begin
					o.full_refused = 1'b1;
				end else begin
					idx = (r.req_type == REQ_INSERT && r.position < lst_count) ?
						r.position : lst_count;
					for (i = lst_count; i > idx; i--)
						lst_data[i] = lst_data[i-1];
					lst_data[idx] = r.item_value;
					lst_count++;
				end
			end
			REQ_POP: begin
				if (lst_count > 0)
					lst_count--;
			end
			REQ_SET: begin
				if (lst_count > 0) begin
					idx = (r.position >= lst_count) ? lst_count - 1 : r.position;
					lst_data[idx] = r.item_value;
				end
			end
			REQ_GET: begin
				if (lst_count > 0) begin
					idx = (r.position >= lst_count) ? lst_count - 1 : r.position;
					o.read_value = lst_data[idx];
				end
			end
			REQ_REMOVE: begin
				if (lst_count > 0) begin
					if (r.position < lst_count) begin
						for (i = r.position; i + 1 < lst_count; i++)
							lst_data[i] = lst_data[i+1];
					end
					lst_count--;
				end
			end
			default: begin
			end
		endcase
		o.front_value = (lst_count > 0) ? lst_data[0] : '0;
		o.back_value  = (lst_count > 0) ? lst_data[lst_count-1] : '0;
		o.entry_count = lst_count[6:0];
		o.is_empty    = (lst_count == 0);
		return o;
	endfunction

	task automatic check_field(input string fname, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : rsp_monitor
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response, expected none, got %h", $time, rsp);
				mismatch_count++;
			end else begin
				want = expected_rsps.pop_front();
				check_field("read_value", want.read_value, rsp.read_value);
				check_field("front_value", want.front_value, rsp.front_value);
				check_field("back_value", want.back_value, rsp.back_value);
				check_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
				check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
				check_field("full_refused", 32'(want.full_refused),
					32'(rsp.full_refused));
			end
		end
	end

	// Offers one request, holds it until the transfer, then records its expected response.
	task automatic send_req(input logic [2:0] op, input logic [IDX_W-1:0] pos,
			input logic [DATA_W-1:0] val);
		req_t item;
		item.req_type   = op;
		item.position   = pos;
		item.item_value = val;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		expected_rsps.push_back(list_apply(item));
	endtask

	// Random request, biased to grow or shrink the list so it sweeps empty to full.
	task automatic send_mixed_req();
		int               r;
		logic [2:0]       op;
		logic [IDX_W-1:0] pos;
		if (grow_bias && lst_count >= CAPACITY && $urandom_range(99) < 30)
			grow_bias = 1'b0;
		else if (!grow_bias && lst_count == 0 && $urandom_range(99) < 30)
			grow_bias = 1'b1;
		else if ($urandom_range(99) == 0)
			grow_bias = !grow_bias;
		r = $urandom_range(99);
		if (grow_bias) begin
			if (r < 30)      op = REQ_PUSH;
			else if (r < 55) op = REQ_INSERT;
			else if (r < 62) op = REQ_POP;
			else if (r < 70) op = REQ_REMOVE;
			else if (r < 80) op = REQ_SET;
			else if (r < 97) op = REQ_GET;
			else             op = $urandom_range(1) ? REQ_UNUSED7 : REQ_UNUSED6;
		end else begin
			if (r < 8)       op = REQ_PUSH;
			else if (r < 16) op = REQ_INSERT;
			else if (r < 45) op = REQ_POP;
			else if (r < 75) op = REQ_REMOVE;
			else if (r < 85) op = REQ_SET;
			else if (r < 97) op = REQ_GET;
			else             op = $urandom_range(1) ? REQ_UNUSED7 : REQ_UNUSED6;
		end
		case ($urandom_range(9))
			0, 1:    pos = IDX_W'($urandom_range(255));
			2:       pos = IDX_W'(lst_count);
			default: pos = (lst_count == 0) ? '0 : IDX_W'($urandom_range(lst_count - 1));
		endcase
		send_req(op, pos, $urandom);
	endtask

	task automatic test_empty_list();
		send_req(REQ_POP, 8'd0, 32'h0000_0000);
		send_req(REQ_REMOVE, 8'd0, 32'h7fff_ffff);
		send_req(REQ_SET, 8'd255, 32'h8000_0000);
		send_req(REQ_GET, 8'd255, 32'hffff_ffff);
		send_req(REQ_GET, 8'd0, 32'h0000_0000);
		send_req(REQ_UNUSED6, 8'h55, 32'h1234_5678);
		send_req(REQ_UNUSED7, 8'haa, 32'hedcb_a987);
	endtask

	task automatic test_index_edges();
		send_req(REQ_PUSH, 8'd0, 32'h8000_0000);
		send_req(REQ_PUSH, 8'd7, 32'h7fff_ffff);
		send_req(REQ_INSERT, 8'd0, 32'h0000_0000);
		send_req(REQ_INSERT, 8'd1, 32'hffff_ffff);
		// past the end: acts as push back
		send_req(REQ_INSERT, 8'd255, 32'h5a5a_a5a5);
		send_req(REQ_GET, 8'd0, 32'h0);
		send_req(REQ_GET, 8'd255, 32'h0);
		send_req(REQ_GET, 8'd2, 32'h0);
		send_req(REQ_SET, 8'd255, 32'h0000_0001);
		send_req(REQ_SET, 8'd0, 32'hffff_fffe);
		send_req(REQ_REMOVE, 8'd1, 32'h0);
		// past the end: acts as pop back
		send_req(REQ_REMOVE, 8'd255, 32'h0);
		send_req(REQ_REMOVE, 8'd0, 32'h0);
		send_req(REQ_POP, 8'd0, 32'h0);
	endtask

	task automatic test_full_list();
		while (lst_count < CAPACITY) begin
			if ($urandom_range(1))
				send_req(REQ_PUSH, IDX_W'($urandom_range(255)), $urandom);
			else
				send_req(REQ_INSERT, IDX_W'($urandom_range(lst_count)), $urandom);
		end
		send_req(REQ_PUSH, 8'd0, 32'h1111_1111);
		send_req(REQ_INSERT, 8'd0, 32'h2222_2222);
		send_req(REQ_INSERT, 8'd200, 32'h3333_3333);
		send_req(REQ_GET, IDX_W'(CAPACITY - 1), 32'h0);
		send_req(REQ_SET, 8'd255, 32'h4444_4444);
		while (lst_count > 0)
			send_req(REQ_REMOVE, IDX_W'($urandom_range(255) & 32'h3f), 32'h0);
	endtask

	task automatic test_backpressure();
		tx_idle_pct   = 0;
		rx_stall_pct <= 0;
		-> hold_go;
		repeat (60)
			send_mixed_req();
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n);
		tx_idle_pct   = tx_pct;
		rx_stall_pct <= rx_pct;
		repeat (n)
			send_mixed_req();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_index_edges();
		test_full_list();
		test_backpressure();
		test_random_traffic(0, 0, 500);
		test_random_traffic(57, 0, 500);
		test_random_traffic(0, 57, 500);
		test_random_traffic(30, 30, 500);
		req_valid    <= 1'b0;
		rx_stall_pct <= 0;
		do
			@(negedge clk);
		while (expected_rsps.size() != 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/iirl_pkg.sv
hw/rtl/iirl_cell.sv
hw/rtl/iirl_reduce.sv
hw/rtl/indexed_insert_remove_list.sv
test/tb_indexed_insert_remove_list.sv
